FILE: rtl/hvd_pkg.sv
// Package: shared constants and types for the HMM Viterbi decoder.
package hvd_pkg;

    localparam int NSTATES_DEF  = 8;
    localparam int NSYMBOLS_DEF = 16;
    localparam int SEQ_MAX_DEF  = 64;

    localparam int VAL_W   = 18;
    localparam int SCORE_W = 32;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 4;
    localparam int SYM_W   = 4;
    localparam int STATE_W = 3;
    localparam int POS_W   = 6;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    typedef enum logic [1:0] {
        ACT_TRANS = 2'd0,
        ACT_EMIT  = 2'd1,
        ACT_INIT  = 2'd2,
        ACT_OBS   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACS,
        ST_ADDE,
        ST_COMMIT,
        ST_FINAL,
        ST_TRACE,
        ST_EMIT
    } state_t;

    // Saturating add of a sign-extended table value to a score.
    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [VAL_W-1:0]   b
    );
        logic signed [SCORE_W:0] s;
        s = SCORE_W'(0) + {a[SCORE_W-1], a} + (SCORE_W+1)'(b);
        if (s[SCORE_W] != s[SCORE_W-1])
        begin
            sat_add = s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        end
        else
        begin
            sat_add = s[SCORE_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/hmm_viterbi_decoder.sv
// Top level: log-domain HMM Viterbi decoder with a shared add-compare-select unit.
// Table loads and dropped observations are handled in the idle state. The first
// observation of a sequence takes one initial-plus-emission add per state, later ones
// NSTATES transition candidates plus one emission add per destination state (one
// saturating add a cycle). A last observation adds the final argmax over the states
// and a traceback, then streams one result a cycle while m_axis_tready is high.
// Reset (rst_n low, asynchronous) clears the sequencer, position and overflow flag;
// tables, scores and backpointers are undefined until written.
module hmm_viterbi_decoder #(
    parameter int NSTATES  = hvd_pkg::NSTATES_DEF,
    parameter int NSYMBOLS = hvd_pkg::NSYMBOLS_DEF,
    parameter int SEQ_MAX  = hvd_pkg::SEQ_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: action[1:0], row[4:2], col[8:5], value[26:9], symbol[30:27], pad[31]
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: state_index[2:0], position[8:3], best_score[40:9], truncated[41], pad
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import hvd_pkg::*;

    localparam int SW = (NSTATES > 1) ? $clog2(NSTATES) : 1;
    localparam int YW = (NSYMBOLS > 1) ? $clog2(NSYMBOLS) : 1;
    localparam int PW = $clog2(SEQ_MAX + 1);
    localparam int TW = $clog2(NSTATES * NSTATES);
    localparam int EW = $clog2(NSTATES * NSYMBOLS);
    localparam int BW = $clog2(SEQ_MAX * NSTATES);
    localparam int QW = $clog2(SEQ_MAX);

    // Decode the incoming transaction.
    logic [1:0]                 in_action;
    logic [ROW_W-1:0]           in_row;
    logic [COL_W-1:0]           in_col;
    logic signed [VAL_W-1:0]    in_value;
    logic [SYM_W-1:0]           in_symbol;
    assign in_action = s_axis_tdata[1:0];
    assign in_row    = s_axis_tdata[4:2];
    assign in_col    = s_axis_tdata[8:5];
    assign in_value  = s_axis_tdata[26:9];
    assign in_symbol = s_axis_tdata[30:27];

    // Table and score storage.
    logic signed [VAL_W-1:0]   trans_mem [NSTATES*NSTATES];
    logic signed [VAL_W-1:0]   emit_mem  [NSTATES*NSYMBOLS];
    logic signed [VAL_W-1:0]   init_mem  [NSTATES];
    logic signed [SCORE_W-1:0] score_mem [NSTATES];
    logic signed [SCORE_W-1:0] next_mem  [NSTATES];
    logic [SW-1:0]             bp_mem    [SEQ_MAX*NSTATES];
    logic [SW-1:0]             seq_mem   [SEQ_MAX];

    state_t state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          ovf_reg, ovf_next;
    logic [SW-1:0] j_reg, j_next, x_reg, x_next;
    logic [YW-1:0] sym_reg, sym_next;
    logic          last_reg, last_next;
    logic signed [SCORE_W-1:0] best_reg, best_next;
    logic [SW-1:0]             arg_reg, arg_next;
    logic [PW-1:0] k_reg, k_next, len_reg, len_next;
    logic [SW-1:0] cur_reg, cur_next;

    // Registered read data of the large memories; addresses come from the next-state
    // values so the data lines up with the sequencer registers.
    logic signed [VAL_W-1:0] trans_q, emit_q;
    logic [SW-1:0]           bp_q, seq_q;
    logic [TW-1:0]           trans_rd_addr, trans_wr_addr;
    logic [EW-1:0]           emit_rd_addr, emit_wr_addr;
    logic [BW-1:0]           bp_rd_addr, bp_wr_addr;
    logic [QW-1:0]           seq_rd_addr;
    assign trans_rd_addr = TW'(32'(x_next) * NSTATES + 32'(j_next));
    assign emit_rd_addr  = EW'(32'(j_next) * NSYMBOLS + 32'(sym_next));
    assign bp_rd_addr    = BW'(32'(k_next) * NSTATES + 32'(cur_next));
    assign seq_rd_addr   = QW'(k_next);
    assign trans_wr_addr = TW'(32'(in_row) * NSTATES + 32'(in_col));
    assign emit_wr_addr  = EW'(32'(in_row) * NSYMBOLS + 32'(in_col));
    assign bp_wr_addr    = BW'(32'(pos_reg) * NSTATES + 32'(j_reg));

    // Range checks for table writes; clamp symbol.
    logic row_ok, tcol_ok, ecol_ok;
    logic [YW-1:0] sym_clamped;
    always_comb
    begin
        row_ok  = 32'(in_row) < NSTATES;
        tcol_ok = 32'(in_col) < NSTATES;
        ecol_ok = 32'(in_col) < NSYMBOLS;
        if (32'(in_symbol) >= NSYMBOLS)
        begin
            sym_clamped = YW'(NSYMBOLS - 1);
        end
        else
        begin
            sym_clamped = YW'(in_symbol);
        end
    end

    logic in_acc, out_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Shared saturating adder: transition candidates in ST_ACS, the emission add
    // (or initial plus emission on the first position) in ST_ADDE.
    logic signed [SCORE_W-1:0] add_a, add_sum;
    logic signed [VAL_W-1:0]   add_b;
    logic                      first_pos;
    logic                      better;
    assign first_pos = (pos_reg == '0);
    always_comb
    begin
        if (state_reg == ST_ACS)
        begin
            add_a = score_mem[x_reg];
            add_b = trans_q;
        end
        else
        begin
            add_b = emit_q;
            if (first_pos)
            begin
                add_a = {{(SCORE_W-VAL_W){init_mem[j_reg][VAL_W-1]}}, init_mem[j_reg]};
            end
            else
            begin
                add_a = best_reg;
            end
        end
    end
    assign add_sum = sat_add(add_a, add_b);
    // Strict compare keeps the lowest index on ties.
    assign better  = (x_reg == '0) || (add_sum > best_reg);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        j_next     = j_reg;
        x_next     = x_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        best_next  = best_reg;
        arg_next   = arg_reg;
        k_next     = k_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_action == ACT_OBS)
                begin
                    sym_next  = sym_clamped;
                    last_next = s_axis_tlast;
                    j_next    = '0;
                    x_next    = '0;
                    if (32'(pos_reg) < SEQ_MAX)
                    begin
                        state_next = first_pos ? ST_ADDE : ST_ACS;
                    end
                    else
                    begin
                        // Drop the observation and flag the run as truncated.
                        ovf_next = 1'b1;
                        if (s_axis_tlast)
                        begin
                            state_next = ST_FINAL;
                        end
                    end
                end
            end
            ST_ACS:
            begin
                // Track the running best over source states.
                if (better)
                begin
                    best_next = add_sum;
                    arg_next  = x_reg;
                end
                if (32'(x_reg) == NSTATES - 1)
                begin
                    x_next     = '0;
                    state_next = ST_ADDE;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            ST_ADDE:
            begin
                if (32'(j_reg) == NSTATES - 1)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = first_pos ? ST_ADDE : ST_ACS;
                end
            end
            ST_COMMIT:
            begin
                pos_next = pos_reg + 1'b1;
                if (last_reg)
                begin
                    state_next = ST_FINAL;
                    x_next     = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (pos_reg == '0)
                begin
                    state_next = ST_IDLE;
                    ovf_next   = 1'b0;
                end
                else
                begin
                    if (x_reg == '0 || score_mem[x_reg] > best_reg)
                    begin
                        best_next = score_mem[x_reg];
                        cur_next  = x_reg;
                    end
                    if (32'(x_reg) == NSTATES - 1)
                    begin
                        state_next = ST_TRACE;
                        len_next   = pos_reg;
                        k_next     = pos_reg - 1'b1;
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                end
            end
            ST_TRACE:
            begin
                // Step back one position a cycle; bp_q holds the pointer of (k, cur).
                if (k_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cur_next = bp_q;
                    k_next   = k_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    if (k_reg == len_reg - 1'b1)
                    begin
                        state_next = ST_IDLE;
                        pos_next   = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        x_reg    <= x_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
        best_reg <= best_next;
        arg_reg  <= arg_next;
        k_reg    <= k_next;
        len_reg  <= len_next;
        cur_reg  <= cur_next;
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        trans_q <= trans_mem[trans_rd_addr];
        emit_q  <= emit_mem[emit_rd_addr];
        bp_q    <= bp_mem[bp_rd_addr];
        seq_q   <= seq_mem[seq_rd_addr];
        if (in_acc && in_action == ACT_TRANS && row_ok && tcol_ok)
        begin
            trans_mem[trans_wr_addr] <= in_value;
        end
        if (in_acc && in_action == ACT_EMIT && row_ok && ecol_ok)
        begin
            emit_mem[emit_wr_addr] <= in_value;
        end
        if (in_acc && in_action == ACT_INIT && row_ok)
        begin
            init_mem[SW'(in_row)] <= in_value;
        end
        if (state_reg == ST_ADDE)
        begin
            next_mem[j_reg] <= add_sum;
            if (!first_pos)
            begin
                bp_mem[bp_wr_addr] <= arg_reg;
            end
        end
        if (state_reg == ST_COMMIT)
        begin
            for (int i = 0; i < NSTATES; i++)
            begin
                score_mem[i] <= next_mem[i];
            end
        end
        if (state_reg == ST_FINAL && state_next == ST_TRACE)
        begin
            seq_mem[QW'(pos_reg - 1'b1)] <= cur_next;
        end
        if (state_reg == ST_TRACE && k_reg != '0)
        begin
            seq_mem[QW'(k_reg - 1'b1)] <= cur_next;
        end
    end

    // Result stream.
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tlast  = (k_reg == len_reg - 1'b1);
    assign m_axis_tdata  = {6'd0, ovf_reg, best_reg,
                            POS_W'(k_reg), STATE_W'(seq_q)};

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while results pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) <= SEQ_MAX)
        else $error("position beyond bound");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && m_axis_tlast) |=> (pos_reg == '0 && !ovf_reg))
        else $error("run state not cleared after traceback");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule
